### hw/rtl/itoaf_pkg.sv
// Shared types, constants and character helpers for the integer-to-ASCII formatter.
`timescale 1ns / 1ps

package itoaf_pkg;

  localparam int PointerBitsDefault = 64;
  localparam int QueueDepth         = 2;
  localparam int CountW             = 31;
  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  // ASCII codes used by the emitter
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLowerA = 8'h61;
  localparam logic [7:0] ChUpperA = 8'h41;
  localparam logic [7:0] ChMinus  = 8'h2d;
  localparam logic [7:0] ChLower0x = 8'h78;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChN      = 8'h6e;
  localparam logic [7:0] ChI      = 8'h69;
  localparam logic [7:0] ChL      = 8'h6c;

  // Reciprocal of ten for 32-bit operands: q = (w * RecipTen) >> RecipShift
  localparam logic [31:0] RecipTen   = 32'hcccccccd;
  localparam int          RecipShift = 35;

  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_HEXL = 3'd2,
    OP_HEXU = 3'd3,
    OP_PTR  = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    KIND_DEC,
    KIND_HEXL,
    KIND_HEXU,
    KIND_PTR,
    KIND_NIL
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PREFIX,
    ST_DIGITS
  } back_state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0]        char_code;
    logic              last;
    logic [CountW-1:0] total_count;
  } out_item_t;

  // Classified job handed from front to back (magnitude travels beside it)
  typedef struct packed {
    kind_e kind;
    logic  neg;
  } job_ctrl_t;

  function automatic logic [2:0] prefix_len(input job_ctrl_t c);
    logic [2:0] n;
    n = 3'd0;
    unique case (c.kind)
      KIND_PTR: n = 3'd2;
      KIND_NIL: n = 3'd5;
      KIND_DEC: n = c.neg ? 3'd1 : 3'd0;
      default:  n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] prefix_char(input kind_e k, input logic [2:0] idx);
    logic [7:0] ch;
    ch = ChMinus;
    if (k == KIND_PTR) begin
      ch = (idx == 3'd0) ? ChZero : ChLower0x;
    end else if (k == KIND_NIL) begin
      unique case (idx)
        3'd0:    ch = ChLParen;
        3'd1:    ch = ChN;
        3'd2:    ch = ChI;
        3'd3:    ch = ChL;
        default: ch = ChRParen;
      endcase
    end
    return ch;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < 4'd10) begin
      ch = ChZero + {4'd0, d};
    end else begin
      ch = (upper ? ChUpperA : ChLowerA) + {4'd0, d} - 8'd10;
    end
    return ch;
  endfunction

endpackage

### hw/rtl/itoaf_front.sv
// Front end: classify an incoming item into a conversion job and its magnitude.
`timescale 1ns / 1ps

module itoaf_front #(
  parameter int POINTER_BITS = itoaf_pkg::PointerBitsDefault,
  parameter int MagW         = (POINTER_BITS > 32) ? POINTER_BITS : 32
) (
  input  itoaf_pkg::in_item_t  item_i,
  output itoaf_pkg::job_ctrl_t ctrl_o,
  output logic [MagW-1:0]      mag_o,
  output logic                 keep_o
);
  import itoaf_pkg::*;

  logic [31:0]             word;
  logic [31:0]             word_neg;
  logic [POINTER_BITS-1:0] ptr;

  assign word     = item_i.value[31:0];
  assign word_neg = 32'd0 - word;
  assign ptr      = item_i.value[POINTER_BITS-1:0];

  always_comb begin
    ctrl_o.kind = KIND_DEC;
    ctrl_o.neg  = 1'b0;
    mag_o       = MagW'(word);
    keep_o      = 1'b1;
    unique case (item_i.opcode)
      OP_SDEC: begin
        ctrl_o.neg = word[31];
        mag_o      = MagW'(word[31] ? word_neg : word);
      end
      OP_UDEC: ctrl_o.kind = KIND_DEC;
      OP_HEXL: ctrl_o.kind = KIND_HEXL;
      OP_HEXU: ctrl_o.kind = KIND_HEXU;
      OP_PTR: begin
        ctrl_o.kind = (ptr == '0) ? KIND_NIL : KIND_PTR;
        mag_o       = MagW'(ptr);
      end
      // unused opcodes: drop the item
      default: keep_o = 1'b0;
    endcase
  end

endmodule

### hw/rtl/itoaf_queue.sv
// Small FIFO that decouples the classifying front end from the emitting back end.
`timescale 1ns / 1ps

module itoaf_queue #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [Width-1:0] rdata_o
);
  import itoaf_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] mem_q [QueueDepth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(QueueDepth));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(QueueDepth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(QueueDepth - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### hw/rtl/itoaf_back.sv
// Back end: digit conversion one digit per cycle, then character emission.
`timescale 1ns / 1ps

module itoaf_back #(
  parameter int POINTER_BITS = itoaf_pkg::PointerBitsDefault,
  parameter int MagW         = (POINTER_BITS > 32) ? POINTER_BITS : 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  input  itoaf_pkg::job_ctrl_t job_ctrl_i,
  input  logic [MagW-1:0]      job_mag_i,
  output logic                 job_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output itoaf_pkg::out_item_t out_data_o
);
  import itoaf_pkg::*;

  localparam int HexDigits = (POINTER_BITS + 3) / 4;
  localparam int DigN      = (HexDigits > 10) ? HexDigits : 10;
  localparam int IdxW      = $clog2(DigN);

  back_state_e      state_q, state_d;
  job_ctrl_t        ctrl_q, ctrl_d;
  logic [MagW-1:0]  mag_q, mag_d;
  logic [3:0]       dig_q [DigN];
  logic [IdxW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  didx_q, didx_d;
  logic [2:0]       pidx_q, pidx_d;
  logic [CountW-1:0] total_q, total_d;
  logic             out_valid_q, out_valid_d;
  out_item_t        out_q, out_d;

  logic             dig_we;
  logic [3:0]       dig_new;
  logic [MagW-1:0]  mag_next;
  logic [63:0]      prod;
  logic [28:0]      quot;
  logic [31:0]      quot10;
  logic [31:0]      rem;
  logic             slot_free;
  logic             emit;
  logic [7:0]       emit_char;
  logic             emit_last;
  logic [2:0]       plen;

  // decimal step: quotient by reciprocal, remainder by subtract
  assign prod   = mag_q[31:0] * RecipTen;
  assign quot   = prod[63:RecipShift];
  assign quot10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
  assign rem    = mag_q[31:0] - quot10;

  always_comb begin
    if (ctrl_q.kind == KIND_DEC) begin
      dig_new  = rem[3:0];
      mag_next = MagW'(quot);
    end else begin
      dig_new  = mag_q[3:0];
      mag_next = mag_q >> 4;
    end
  end

  assign plen      = prefix_len(ctrl_q);
  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    ctrl_d      = ctrl_q;
    mag_d       = mag_q;
    cnt_d       = cnt_q;
    didx_d      = didx_q;
    pidx_d      = pidx_q;
    job_pop_o   = 1'b0;
    dig_we      = 1'b0;
    emit        = 1'b0;
    emit_char   = ChZero;
    emit_last   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          ctrl_d    = job_ctrl_i;
          mag_d     = job_mag_i;
          cnt_d     = '0;
          pidx_d    = '0;
          state_d   = (job_ctrl_i.kind == KIND_NIL) ? ST_PREFIX : ST_CONV;
        end
      end
      ST_CONV: begin
        dig_we = 1'b1;
        mag_d  = mag_next;
        cnt_d  = cnt_q + 1'b1;
        if (mag_next == '0) begin
          didx_d  = cnt_q;
          state_d = (plen != 3'd0) ? ST_PREFIX : ST_DIGITS;
        end
      end
      ST_PREFIX: begin
        emit_char = prefix_char(ctrl_q.kind, pidx_q);
        emit_last = (ctrl_q.kind == KIND_NIL) && (pidx_q == plen - 3'd1);
        if (slot_free) begin
          emit   = 1'b1;
          pidx_d = pidx_q + 3'd1;
          if (pidx_q == plen - 3'd1) begin
            state_d = (ctrl_q.kind == KIND_NIL) ? ST_IDLE : ST_DIGITS;
          end
        end
      end
      ST_DIGITS: begin
        emit_char = digit_char(dig_q[didx_q], ctrl_q.kind == KIND_HEXU);
        emit_last = (didx_q == '0);
        if (slot_free) begin
          emit   = 1'b1;
          didx_d = didx_q - 1'b1;
          if (didx_q == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // output register and running character count
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    total_d     = total_q;
    if (emit) begin
      total_d           = (total_q == CountMax) ? total_q : total_q + 1'b1;
      out_valid_d       = 1'b1;
      out_d.char_code   = emit_char;
      out_d.last        = emit_last;
      out_d.total_count = total_d;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ctrl_q <= ctrl_d;
    mag_q  <= mag_d;
    cnt_q  <= cnt_d;
    didx_q <= didx_d;
    pidx_q <= pidx_d;
    out_q  <= out_d;
    if (dig_we) begin
      dig_q[cnt_q] <= dig_new;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hw/rtl/integer_to_ascii_formatter.sv
// Top level of the integer-to-ASCII formatter: front end, job queue, back end.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one number with an
//   opcode per transfer: signed decimal, unsigned decimal, lower or upper hex of
//   the low 32 bits, or a pointer form ("0x" plus hex, "(nil)" for zero) of the
//   low POINTER_BITS bits. Unused opcodes are taken and dropped without output.
//   Output channel (out_valid_o / out_ready_i / out_data_o) carries one ASCII
//   character per transfer, most significant first, with last set on the final
//   character of the item and a saturating running count of characters.
//   Flow: a classified item enters a two-entry queue; the back end then loads it,
//   converts it digit by digit (up to 10 decimal, 8 hex, or (POINTER_BITS+3)/4
//   pointer digits; none for "(nil)"), then emits its prefix and digit
//   characters. The back end takes the next item only after the last character
//   of the current item has been emitted.
//   The front keeps taking items while the queue has room, so the input side
//   runs ahead of a stalled receiver by up to two queued items plus the one in the back end.
//   Reset (rst_ni low, asynchronous) empties the queue, idles the back end,
//   drops any pending character and clears the character count.
//   When the receiver stalls, the held character and count stay stable and
//   emission of the current item halts at its next character.

module integer_to_ascii_formatter #(
  parameter int POINTER_BITS = itoaf_pkg::PointerBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  itoaf_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output itoaf_pkg::out_item_t out_data_o
);
  import itoaf_pkg::*;

  localparam int MagW   = (POINTER_BITS > 32) ? POINTER_BITS : 32;
  localparam int CtrlW  = $bits(job_ctrl_t);
  localparam int EntryW = CtrlW + MagW;

  job_ctrl_t         front_ctrl;
  logic [MagW-1:0]   front_mag;
  logic              front_keep;
  logic              q_full;
  logic              q_valid;
  logic              q_pop;
  logic [EntryW-1:0] q_rdata;
  job_ctrl_t         back_ctrl;
  logic [MagW-1:0]   back_mag;

  // Classify the incoming item
  itoaf_front #(
    .POINTER_BITS(POINTER_BITS),
    .MagW        (MagW)
  ) u_front (
    .item_i(in_data_i),
    .ctrl_o(front_ctrl),
    .mag_o (front_mag),
    .keep_o(front_keep)
  );

  // Accept whenever the queue has room; drop items with unused opcodes
  assign in_ready_o = !q_full;

  itoaf_queue #(
    .Width(EntryW)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_valid_i && front_keep),
    .wdata_i({front_ctrl, front_mag}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .rdata_o(q_rdata)
  );

  assign back_ctrl = job_ctrl_t'(q_rdata[EntryW-1:MagW]);
  assign back_mag  = q_rdata[MagW-1:0];

  // Convert and emit characters
  itoaf_back #(
    .POINTER_BITS(POINTER_BITS),
    .MagW        (MagW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_ctrl_i (back_ctrl),
    .job_mag_i  (back_mag),
    .job_pop_o  (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

### hw/rtl/itoaf_checker.sv
// Port-level checks for the integer-to-ASCII formatter, bound to the top level.
`timescale 1ns / 1ps

module itoaf_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input itoaf_pkg::out_item_t out_data_o
);
  import itoaf_pkg::*;

  // Hold a stalled character unchanged
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output changed");

  // Count advances by one per transfer until saturated
  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o && out_ready_i) |->
      (out_data_o.total_count == $past(out_data_o.total_count) + 31'd1) ||
      (out_data_o.total_count == CountMax))
    else $error("character count did not advance");

  // Every shown character has been counted
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.total_count != '0)
    else $error("character shown with zero count");

  // A minus sign is always followed by digits
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.char_code == ChMinus |-> !out_data_o.last)
    else $error("minus sign marked last");

endmodule

bind integer_to_ascii_formatter itoaf_checker u_itoaf_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

### bench/integer_to_ascii_formatter_chk.sv
// Scoreboard for the integer-to-ASCII formatter: predicts each character and checks the output.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_chk #(
  parameter int POINTER_BITS = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  itoaf_pkg::in_item_t  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  itoaf_pkg::out_item_t out_data_i,
  output int unsigned          errors_o,
  output int unsigned          pending_o,
  output int unsigned          chars_o
);
  import itoaf_pkg::*;

  localparam logic [63:0] PtrMask = {64{1'b1}} >> (64 - POINTER_BITS);

  out_item_t         char_q[$];
  logic [CountW-1:0] char_total;

  // Render one number as text and queue its characters with the running count.
  task automatic format_number(input in_item_t num);
    logic [7:0]  text [24];
    logic [7:0]  digits [20];
    string       hex_digits;
    logic [31:0] word;
    logic [63:0] addr;
    int          n;
    int          r;
    out_item_t   want;
    n = 0;
    r = 0;
    word = num.value[31:0];
    addr = num.value & PtrMask;
    hex_digits = (num.opcode == OP_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";
    case (num.opcode)
      OP_SDEC, OP_UDEC: begin
        // negate in 32 bits: the most negative value keeps its exact magnitude
        if (num.opcode == OP_SDEC && word[31]) begin
          text[n] = "-";
          n = n + 1;
          word = -word;
        end
        do begin
          digits[r] = "0" + 8'(word % 10);
          r = r + 1;
          word = word / 10;
        end while (word != 0);
      end
      OP_HEXL, OP_HEXU: begin
        do begin
          digits[r] = hex_digits[word[3:0]];
          r = r + 1;
          word = word >> 4;
        end while (word != 0);
      end
      OP_PTR: begin
        if (addr == 0) begin
          text[0] = "(";
          text[1] = "n";
          text[2] = "i";
          text[3] = "l";
          text[4] = ")";
          n = 5;
        end else begin
          text[0] = "0";
          text[1] = "x";
          n = 2;
          while (addr != 0) begin
            digits[r] = hex_digits[addr[3:0]];
            r = r + 1;
            addr = addr >> 4;
          end
        end
      end
      default: ;  // unused opcode: no text, count untouched
    endcase
    while (r > 0) begin
      r = r - 1;
      text[n] = digits[r];
      n = n + 1;
    end
    for (int i = 0; i < n; i++) begin
      if (char_total != CountMax) char_total = char_total + 1'b1;
      want.char_code   = text[i];
      want.last        = (i == n - 1);
      want.total_count = char_total;
      char_q.push_back(want);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_item_t want;
    if (!rst_ni) begin
      char_q.delete();
      char_total = '0;
    end else begin
      if (in_valid_i && in_ready_i) format_number(in_data_i);
      if (out_valid_i && out_ready_i) begin
        chars_o = chars_o + 1;
        if (char_q.size() == 0) begin
          errors_o = errors_o + 1;
          $display("%0t: unexpected character, expected none, actual %h last %b count %0d",
                   $time, out_data_i.char_code, out_data_i.last, out_data_i.total_count);
        end else begin
          want = char_q.pop_front();
          if (out_data_i.char_code !== want.char_code) begin
            errors_o = errors_o + 1;
            $display("%0t: char_code expected %h actual %h",
                     $time, want.char_code, out_data_i.char_code);
          end
          if (out_data_i.last !== want.last) begin
            errors_o = errors_o + 1;
            $display("%0t: last expected %b actual %b", $time, want.last, out_data_i.last);
          end
          if (out_data_i.total_count !== want.total_count) begin
            errors_o = errors_o + 1;
            $display("%0t: total_count expected %0d actual %0d",
                     $time, want.total_count, out_data_i.total_count);
          end
        end
      end
    end
    pending_o = char_q.size();
  end

endmodule

### bench/integer_to_ascii_formatter_tb.sv
// Top of the integer-to-ASCII formatter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module integer_to_ascii_formatter_tb;
  import itoaf_pkg::*;

  localparam int PointerBits  = 64;
  localparam int RandomItems  = 210;
  localparam int DrainCycles  = 50;
  localparam int CycleLimit   = 400000;

  // Opcodes past the pointer form carry no meaning; the block takes and drops them.
  localparam logic [2:0] OpFirstUnused = 3'd5;
  localparam logic [2:0] OpMidUnused   = 3'd6;
  localparam logic [2:0] OpLastUnused  = 3'd7;

  // Receiver behavior, switched each time rx_phase wraps.
  typedef enum logic [1:0] {
    RX_OPEN,      // always ready
    RX_LIGHT,     // ready with chance three in four, at random
    RX_HEAVY,     // ready with chance one in four, at random
    RX_PERIODIC   // ready on a fixed one-in-four beat
  } rx_mode_e;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  int unsigned errors;
  int unsigned pending;
  int unsigned chars_seen;
  int unsigned cycles = 0;
  int unsigned numbers_sent = 0;
  int unsigned unused_sent = 0;

  logic [5:0]  rx_phase = '0;
  rx_mode_e    rx_mode = RX_OPEN;

  integer_to_ascii_formatter #(
    .POINTER_BITS(PointerBits)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // The checker watches both channels, predicts the text and compares every transfer.
  integer_to_ascii_formatter_chk #(
    .POINTER_BITS(PointerBits)
  ) chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .chars_o    (chars_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver: pick a stall pattern each time rx_phase wraps so stalls land on every
  // character position, with open stretches in between.
  always @(posedge clk_i) begin
    rx_phase <= rx_phase + 1'b1;
    if (rx_phase == '1) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:  out_ready <= 1'b1;
      RX_LIGHT: out_ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ready <= ($urandom_range(0, 3) == 0);
      default:  out_ready <= (rx_phase[1:0] == 2'b00);
    endcase
  end

  // Watchdog: end the run if the expected text never drains.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: timeout with %0d characters still expected", $time, pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offer one number and hold it until the block takes it.
  task automatic send_number(input logic [2:0] opcode, input logic [63:0] value);
    in_valid <= 1'b1;
    in_data  <= '{opcode: opcode, value: value};
    do @(posedge clk_i); while (!in_ready);
    if (opcode > OP_PTR) unused_sent++;
    else numbers_sent++;
  endtask

  // Drop valid for a gap between bursts.
  task automatic pause_sender(input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold off until every queued character has come out.
  // Sample the count on the falling edge, then resume on a rising one.
  task automatic drain_output();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [2:0] random_opcode();
    if ($urandom_range(0, 9) == 0) return 3'($urandom_range(OpFirstUnused, OpLastUnused));
    return 3'($urandom_range(int'(OP_SDEC), int'(OP_PTR)));
  endfunction

  // Mix full-width noise with shapes that vary the digit count and hit sign edges.
  function automatic logic [63:0] random_value();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0:       return wide;
      1:       return 64'($urandom_range(0, 20));
      2:       return wide >> $urandom_range(0, 63);
      3:       return {$urandom, 32'hffff_ffff - 32'($urandom_range(0, 3))};
      4:       return 64'h1 << $urandom_range(0, 63);
      default: return {$urandom, 32'h8000_0000 + 32'($urandom_range(0, 2))};
    endcase
  endfunction

  initial begin : stimulus
    int unsigned target;
    int          burst;
    bit          pressured;
    pressured = 1'b0;
    rst_ni   = 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero, sign edges, full-width values and every form.
    // Upper garbage in the 32-bit forms must be ignored.
    send_number(OP_SDEC, 64'h0);
    send_number(OP_SDEC, 64'hffff_ffff_0000_0001);
    send_number(OP_SDEC, 64'h0000_0000_ffff_ffff);
    send_number(OP_SDEC, 64'h1234_5678_8000_0000);  // most negative value, full text
    send_number(OP_SDEC, 64'h0000_0000_7fff_ffff);
    send_number(OP_UDEC, 64'hffff_ffff_0000_0000);
    send_number(OP_UDEC, 64'h0000_0000_ffff_ffff);
    send_number(OP_UDEC, 64'h0000_0000_3b9a_ca00);
    send_number(OP_HEXL, 64'h0);
    send_number(OP_HEXL, 64'h0000_0000_dead_beef);
    send_number(OP_HEXL, 64'hffff_ffff_ffff_ffff);
    send_number(OP_HEXU, 64'h0);
    send_number(OP_HEXU, 64'h0000_0000_abcd_ef01);
    send_number(OP_HEXU, 64'h5555_5555_ffff_ffff);
    send_number(OP_PTR,  64'h0);                    // prints the nil form
    send_number(OP_PTR,  64'h1);
    send_number(OP_PTR,  64'hffff_ffff_0000_0000);
    send_number(OP_PTR,  64'hffff_ffff_ffff_ffff);
    send_number(OP_PTR,  64'h0000_0001_0000_0000);
    send_number(OpFirstUnused, 64'hffff_ffff_ffff_ffff);
    send_number(OpMidUnused, 64'h0);
    send_number(OpLastUnused, 64'h1234_5678_9abc_def0);
    send_number(OP_SDEC, 64'h0000_0000_0000_0009);
    drain_output();

    // Random bursts; a third of the gaps are zero so long runs go back to back.
    target = numbers_sent + RandomItems;
    while (numbers_sent < target) begin
      burst = $urandom_range(1, 10);
      for (int b = 0; b < burst; b++) send_number(random_opcode(), random_value());
      if ($urandom_range(0, 2) == 0) pause_sender(0);
      else pause_sender($urandom_range(1, 8));
      if (!pressured && numbers_sent >= target - RandomItems / 2) begin
        drain_output();
        pressured = 1'b1;
      end
    end

    drain_output();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d numbers over all five forms and %0d unused-opcode transfers;",
             numbers_sent, unused_sent);
    $display("%0d characters checked under bursty input and mixed output stalls.",
             chars_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
